/* rtl/lsbf_pkg.sv */
// Package for the laser scan box filter: constants, register codes and the
// sine ROM contents. No dependencies.
`default_nettype none
package lsbf_pkg;

   localparam int RangeMinMm  = 20;
   localparam int TableBits   = 12;
   localparam int SineDepth   = 1 << TableBits;
   localparam int SineQuarter = SineDepth >> 2;
   localparam int CsrAddrW    = 5;
   localparam int CsrDataW    = 32;
   localparam int PosW        = 18;
   localparam real Pi         = 3.14159265358979323846;

   typedef logic signed [15:0] sine_word_type;
   typedef sine_word_type sine_rom_type [SineDepth];
   typedef logic [TableBits-1:0] sine_index_type;

   typedef enum logic [2:0] {
      REG_KEEP_INSIDE = 3'd0,
      REG_BOX_MAX_X   = 3'd1,
      REG_BOX_MAX_Y   = 3'd2,
      REG_BOX_MIN_X   = 3'd3,
      REG_BOX_MIN_Y   = 3'd4,
      REG_RANGE_UPPER = 3'd5,
      REG_ANGLE_START = 3'd6,
      REG_ANGLE_STEP  = 3'd7
   } csr_index_type;

   localparam logic        KeepInsideRst = 1'b1;
   localparam logic [15:0] BoxMaxXRst    = 16'd30;
   localparam logic [15:0] BoxMaxYRst    = 16'd300;
   localparam logic [15:0] BoxMinXRst    = 16'hFB50;  // -1200
   localparam logic [15:0] BoxMinYRst    = 16'hFED4;  // -300
   localparam logic [15:0] RangeUpperRst = 16'hFFFF;

   // round(32767*sin), built from the first quadrant by symmetry
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      int quad;
      int r;
      int m;
      int iv;
      real v;
      for (int k = 0; k < SineDepth; k++) begin
         quad = k >> (TableBits - 2);
         r    = k & (SineQuarter - 1);
         m    = ((quad & 1) != 0) ? SineQuarter - r : r;
         v    = 32767.0 * $sin(2.0 * Pi * m / SineDepth);
         iv   = $rtoi(v + 0.5);
         if ((quad & 2) != 0) begin
            iv = -iv;
         end
         rom[k] = sine_word_type'(iv);
      end
      return rom;
   endfunction

endpackage
`default_nettype wire

/* rtl/lsbf_req_if.sv */
// Input channel of the laser scan box filter: one range sample per transfer.
// No dependencies.
`default_nettype none
interface lsbf_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] range_mm;
   logic        first_of_scan;

   modport source (output valid, output range_mm, output first_of_scan, input ready);
   modport sink   (input valid, input range_mm, input first_of_scan, output ready);
endinterface
`default_nettype wire

/* rtl/lsbf_rsp_if.sv */
// Result channel of the laser scan box filter: range and removed flag.
// No dependencies.
`default_nettype none
interface lsbf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] range_out;
   logic        removed;

   modport source (output valid, output range_out, output removed, input ready);
   modport sink   (input valid, input range_out, input removed, output ready);
endinterface
`default_nettype wire

/* rtl/laser_scan_box_filter_core.sv */
// Laser scan box filter top level: beam angle tracking, sine ROM, polar to
// cartesian conversion and box test. Depends on lsbf_pkg, lsbf_req_if, lsbf_rsp_if.
//
// Usage: range samples enter on req (valid/ready), one beam per transfer; a
// sample with first_of_scan loads the beam angle from angle_start, any other
// adds angle_step. Each sample yields exactly one transfer on rsp carrying the
// unchanged range and a removed flag set when the range is within its limits
// and the box test rejects the point. Registers are written over the APB-style
// csr port at byte address 4*index; the user must write them only while the
// block is idle, which the block does not enforce. Reads return the register
// value. Each item is registered at the ROM read, multiply and compare stages
// in turn. Throughput: one sample per cycle while rsp is not stalled, set by
// the dual-port sine ROM read and one 17x16 multiplier per coordinate. Each
// stage holds its item while the next is full, so a stalled rsp only backs up
// the pipe; req stays ready while any stage has room. Reset (synchronous)
// empties the pipe, clears the beam angle and loads the register defaults.
`default_nettype none
module laser_scan_box_filter_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   lsbf_req_if.sink                        req,
   lsbf_rsp_if.source                      rsp,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [lsbf_pkg::CsrAddrW-1:0] csr_paddr,
   input  wire logic [lsbf_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [lsbf_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                            csr_pready
);
   import lsbf_pkg::*;

   localparam sine_rom_type SineRom = build_sine_rom();

   logic        keep_inside_ff;
   logic [15:0] box_max_x_ff, box_max_y_ff, box_min_x_ff, box_min_y_ff;
   logic [15:0] range_upper_ff, angle_start_ff, angle_step_ff;
   logic [15:0] beam_angle_ff, beam_angle_in;

   logic        csr_write;
   csr_index_type csr_index;

   logic        v1_ff, v2_ff, v3_ff;
   logic        ready1, ready2, ready3;
   logic        req_xfer;
   logic [15:0] range1_ff, range2_ff, range3_ff;
   sine_word_type sin1_ff, cos1_ff;
   logic signed [PosW-1:0] x2_ff, y2_ff;
   logic        removed3_ff, removed3_in;
   sine_index_type sin_idx, cos_idx;
   logic signed [32:0] prod_x, prod_y;
   logic signed [PosW-1:0] max_x, max_y, min_x, min_y;
   logic        range_valid, in_box;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[CsrAddrW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_inside_ff <= KeepInsideRst;
         box_max_x_ff   <= BoxMaxXRst;
         box_max_y_ff   <= BoxMaxYRst;
         box_min_x_ff   <= BoxMinXRst;
         box_min_y_ff   <= BoxMinYRst;
         range_upper_ff <= RangeUpperRst;
         angle_start_ff <= 16'd0;
         angle_step_ff  <= 16'd0;
      end else if (csr_write) begin
         case (csr_index)
            REG_KEEP_INSIDE: keep_inside_ff <= csr_pwdata[0];
            REG_BOX_MAX_X:   box_max_x_ff   <= csr_pwdata[15:0];
            REG_BOX_MAX_Y:   box_max_y_ff   <= csr_pwdata[15:0];
            REG_BOX_MIN_X:   box_min_x_ff   <= csr_pwdata[15:0];
            REG_BOX_MIN_Y:   box_min_y_ff   <= csr_pwdata[15:0];
            REG_RANGE_UPPER: range_upper_ff <= csr_pwdata[15:0];
            REG_ANGLE_START: angle_start_ff <= csr_pwdata[15:0];
            REG_ANGLE_STEP:  angle_step_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_KEEP_INSIDE: csr_prdata = {{(CsrDataW-1){1'b0}}, keep_inside_ff};
         REG_BOX_MAX_X:   csr_prdata = {16'd0, box_max_x_ff};
         REG_BOX_MAX_Y:   csr_prdata = {16'd0, box_max_y_ff};
         REG_BOX_MIN_X:   csr_prdata = {16'd0, box_min_x_ff};
         REG_BOX_MIN_Y:   csr_prdata = {16'd0, box_min_y_ff};
         REG_RANGE_UPPER: csr_prdata = {16'd0, range_upper_ff};
         REG_ANGLE_START: csr_prdata = {16'd0, angle_start_ff};
         REG_ANGLE_STEP:  csr_prdata = {16'd0, angle_step_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // pipeline flow control
   assign ready3    = !v3_ff || rsp.ready;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req.ready = ready1;
   assign req_xfer  = req.valid && ready1;

   // beam angle and ROM addressing
   assign beam_angle_in = req.first_of_scan ? angle_start_ff
                                            : beam_angle_ff + angle_step_ff;
   assign sin_idx = beam_angle_in[15 -: TableBits];
   assign cos_idx = sin_idx + sine_index_type'(SineQuarter);

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_angle_ff <= 16'd0;
      end else if (req_xfer) begin
         beam_angle_ff <= beam_angle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= req.valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // stage 1: ROM read
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         range1_ff <= req.range_mm;
         sin1_ff   <= SineRom[sin_idx];
         cos1_ff   <= SineRom[cos_idx];
      end
   end

   // stage 2: multiply, floor shift by 15
   assign prod_x = $signed({1'b0, range1_ff}) * cos1_ff;
   assign prod_y = $signed({1'b0, range1_ff}) * sin1_ff;

   always_ff @(posedge clock) begin
      if (ready2 && v1_ff) begin
         range2_ff <= range1_ff;
         x2_ff     <= prod_x[32:15];
         y2_ff     <= prod_y[32:15];
      end
   end

   // stage 3: box test
   assign max_x = {{(PosW-16){box_max_x_ff[15]}}, box_max_x_ff};
   assign max_y = {{(PosW-16){box_max_y_ff[15]}}, box_max_y_ff};
   assign min_x = {{(PosW-16){box_min_x_ff[15]}}, box_min_x_ff};
   assign min_y = {{(PosW-16){box_min_y_ff[15]}}, box_min_y_ff};

   assign range_valid = (range2_ff > 16'(RangeMinMm)) && (range2_ff < range_upper_ff);
   assign in_box      = (x2_ff < max_x) && (x2_ff > min_x) &&
                        (y2_ff < max_y) && (y2_ff > min_y);
   assign removed3_in = range_valid && (keep_inside_ff ? !in_box : in_box);

   always_ff @(posedge clock) begin
      if (ready3 && v2_ff) begin
         range3_ff   <= range2_ff;
         removed3_ff <= removed3_in;
      end
   end

   assign rsp.valid     = v3_ff;
   assign rsp.range_out = range3_ff;
   assign rsp.removed   = removed3_ff;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("result valid right after reset");

   a_first_loads_angle: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.first_of_scan |=> beam_angle_ff == $past(angle_start_ff))
      else $error("first_of_scan did not load angle_start");

   a_short_range_kept: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.range_out <= 16'(RangeMinMm)) |-> !rsp.removed)
      else $error("out-of-range sample flagged removed");

   a_stall_holds_stage2: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !ready2 |=> v2_ff && $stable(range2_ff) && $stable(x2_ff))
      else $error("stage 2 lost its item under stall");
`endif

endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for laser_scan_box_filter_core: random range samples with
// scan marks, a cycle-free predictor of the box filter, and APB register setup.
// Depends on lsbf_pkg, lsbf_req_if, lsbf_rsp_if and the core.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lsbf_pkg::*;

   typedef struct packed {
      logic [15:0] range_mm;
      logic        first_of_scan;
   } beam_sample_type;

   typedef struct packed {
      logic [15:0] range_out;
      logic        removed;
   } filtered_beam_type;

   typedef struct {
      logic               keep_inside;
      logic signed [15:0] max_x;
      logic signed [15:0] max_y;
      logic signed [15:0] min_x;
      logic signed [15:0] min_y;
      logic [15:0]        range_upper;
      logic signed [15:0] angle_start;
      logic signed [15:0] angle_step;
   } filter_cfg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   lsbf_req_if req_bus ();
   lsbf_rsp_if rsp_bus ();

   laser_scan_box_filter_core uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   sine_word_type      trig_lut [SineDepth];
   filter_cfg_type     cfg_now;
   logic [15:0]        beam_angle_now;

   beam_sample_type    pending_beams [$];
   filtered_beam_type  expected_beams [$];
   filtered_beam_type  oldest_beam;
   beam_sample_type    next_beam;
   logic               req_in_flight = 1'b0;
   int                 req_gap = 0;
   int                 rsp_gap = 0;
   logic               idling_on = 1'b1;

   int                 mismatch_cnt = 0;
   int                 accepted_cnt = 0;
   int                 checked_cnt = 0;
   int                 removed_cnt = 0;
   int                 setting_cnt = 0;

   function automatic filtered_beam_type filter_beam(beam_sample_type s);
      filtered_beam_type r;
      sine_index_type sidx;
      sine_index_type cidx;
      int             px;
      int             py;
      logic           in_box;
      if (s.first_of_scan) begin
         beam_angle_now = cfg_now.angle_start;
      end else begin
         beam_angle_now = beam_angle_now + cfg_now.angle_step;
      end
      r.range_out = s.range_mm;
      r.removed   = 1'b0;
      if (int'(s.range_mm) > RangeMinMm && s.range_mm < cfg_now.range_upper) begin
         sidx = beam_angle_now[15 -: TableBits];
         cidx = sidx + sine_index_type'(SineQuarter);
         px = (int'(s.range_mm) * int'(trig_lut[cidx])) >>> 15;
         py = (int'(s.range_mm) * int'(trig_lut[sidx])) >>> 15;
         in_box = px < int'(cfg_now.max_x) && px > int'(cfg_now.min_x) &&
                  py < int'(cfg_now.max_y) && py > int'(cfg_now.min_y);
         r.removed = cfg_now.keep_inside ? !in_box : in_box;
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endtask

   // input side: drive at falling edge, record transfers at rising edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_in_flight) begin
         if (req_gap != 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_beams.size() != 0) begin
            next_beam = pending_beams.pop_front();
            req_bus.range_mm      <= next_beam.range_mm;
            req_bus.first_of_scan <= next_beam.first_of_scan;
            req_bus.valid         <= 1'b1;
            req_in_flight = 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(1, 11);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         expected_beams.push_back(filter_beam({req_bus.range_mm, req_bus.first_of_scan}));
         req_in_flight = 1'b0;
         accepted_cnt++;
      end
   end

   // result side
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (idling_on && $urandom_range(0, 9) == 0) begin
            rsp_gap = $urandom_range(1, 11);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_beams.size() == 0) begin
            report_mismatch($sformatf("unexpected result range_out=%0d removed=%0b",
                                      rsp_bus.range_out, rsp_bus.removed));
         end else begin
            oldest_beam = expected_beams.pop_front();
            checked_cnt++;
            if (oldest_beam.removed) begin
               removed_cnt++;
            end
            if (rsp_bus.range_out !== oldest_beam.range_out) begin
               report_mismatch($sformatf("range_out expected %0d got %0d",
                                         oldest_beam.range_out, rsp_bus.range_out));
            end
            if (rsp_bus.removed !== oldest_beam.removed) begin
               report_mismatch($sformatf("removed expected %0b got %0b (range %0d)",
                                         oldest_beam.removed, rsp_bus.removed,
                                         oldest_beam.range_out));
            end
         end
      end
   end

   task automatic csr_write(csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      if (idx == REG_KEEP_INSIDE) begin
         csr_pwdata <= {31'($urandom), value[0]};
      end else begin
         csr_pwdata <= {16'($urandom), value};
      end
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_KEEP_INSIDE: cfg_now.keep_inside = value[0];
         REG_BOX_MAX_X:   cfg_now.max_x       = value;
         REG_BOX_MAX_Y:   cfg_now.max_y       = value;
         REG_BOX_MIN_X:   cfg_now.min_x       = value;
         REG_BOX_MIN_Y:   cfg_now.min_y       = value;
         REG_RANGE_UPPER: cfg_now.range_upper = value;
         REG_ANGLE_START: cfg_now.angle_start = value;
         REG_ANGLE_STEP:  cfg_now.angle_step  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_filter_cfg(filter_cfg_type c);
      csr_write(REG_KEEP_INSIDE, {15'($urandom), c.keep_inside});
      csr_write(REG_BOX_MAX_X, c.max_x);
      csr_write(REG_BOX_MAX_Y, c.max_y);
      csr_write(REG_BOX_MIN_X, c.min_x);
      csr_write(REG_BOX_MIN_Y, c.min_y);
      csr_write(REG_RANGE_UPPER, c.range_upper);
      csr_write(REG_ANGLE_START, c.angle_start);
      csr_write(REG_ANGLE_STEP, c.angle_step);
      setting_cnt++;
   endtask

   task automatic drain_pipe();
      do @(negedge clock);
      while (pending_beams.size() != 0 || req_in_flight || expected_beams.size() != 0);
      repeat (5) @(negedge clock);
   endtask

   task automatic push_beam(int rng, logic first);
      pending_beams.push_back({16'(rng), first});
   endtask

   function automatic filter_cfg_type random_cfg();
      filter_cfg_type c;
      c.keep_inside = 1'($urandom_range(0, 1));
      c.min_x = 16'(int'($urandom_range(0, 6000)) - 3000);
      c.min_y = 16'(int'($urandom_range(0, 6000)) - 3000);
      c.max_x = c.min_x + 16'($urandom_range(0, 4000));
      c.max_y = c.min_y + 16'($urandom_range(0, 4000));
      if ($urandom_range(0, 7) == 0) begin
         c.max_x = c.min_x - 16'($urandom_range(0, 50));
      end
      c.range_upper = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(500, 65535));
      c.angle_start = 16'($urandom);
      case ($urandom_range(0, 2))
         0:       c.angle_step = 16'($urandom);
         1:       c.angle_step = 16'($urandom_range(0, 600));
         default: c.angle_step = -16'($urandom_range(0, 600));
      endcase
      return c;
   endfunction

   function automatic logic [15:0] random_range();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(0, 40));
         2:       return cfg_now.range_upper + 16'(int'($urandom_range(0, 3)) - 2);
         default: return 16'($urandom_range(21, 4000));
      endcase
   endfunction

   initial begin
      real            v;
      int             iv;
      filter_cfg_type c;
      int             scan_left;
      logic           first;

      req_bus.valid         = 1'b0;
      req_bus.range_mm      = '0;
      req_bus.first_of_scan = 1'b0;
      rsp_bus.ready         = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      for (int k = 0; k < SineDepth; k++) begin
         v = 32767.0 * $sin(2.0 * Pi * k / SineDepth);
         iv = (v >= 0.0) ? int'($floor(v + 0.5)) : -int'($floor(0.5 - v));
         trig_lut[k] = sine_word_type'(iv);
      end
      cfg_now.keep_inside = KeepInsideRst;
      cfg_now.max_x       = BoxMaxXRst;
      cfg_now.max_y       = BoxMaxYRst;
      cfg_now.min_x       = BoxMinXRst;
      cfg_now.min_y       = BoxMinYRst;
      cfg_now.range_upper = RangeUpperRst;
      cfg_now.angle_start = '0;
      cfg_now.angle_step  = '0;
      beam_angle_now      = '0;
      setting_cnt         = 1;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults, unmarked samples before any scan start, range limits
      push_beam(0, 1'b0);
      push_beam(20, 1'b0);
      push_beam(21, 1'b0);
      push_beam(29, 1'b0);
      push_beam(30, 1'b0);
      push_beam(31, 1'b0);
      push_beam(65535, 1'b0);
      push_beam(65534, 1'b0);
      push_beam(1000, 1'b1);
      drain_pipe();

      // point exactly on an edge of the box, range at its upper limit
      c = '{keep_inside: 1'b1, max_x: 16'sd99, max_y: 16'sd1, min_x: -16'sd32768,
            min_y: -16'sd1, range_upper: 16'd1000, angle_start: 16'sd0, angle_step: 16'sd0};
      load_filter_cfg(c);
      push_beam(100, 1'b1);
      push_beam(99, 1'b0);
      push_beam(1000, 1'b0);
      push_beam(999, 1'b0);
      drain_pipe();

      // inverted box in both modes
      c = '{keep_inside: 1'b1, max_x: 16'sd100, max_y: 16'sd32767, min_x: 16'sd200,
            min_y: -16'sd32768, range_upper: 16'hFFFF, angle_start: 16'sd0,
            angle_step: 16'sd0};
      load_filter_cfg(c);
      push_beam(50, 1'b1);
      push_beam(150, 1'b0);
      push_beam(65000, 1'b0);
      drain_pipe();
      c.keep_inside = 1'b0;
      load_filter_cfg(c);
      push_beam(50, 1'b1);
      push_beam(150, 1'b0);
      push_beam(65000, 1'b0);
      drain_pipe();

      for (int phase = 0; phase < 8; phase++) begin
         c = random_cfg();
         case (phase)
            0: c = '{keep_inside: 1'b0, max_x: 16'sd32767, max_y: 16'sd32767,
                     min_x: -16'sd32768, min_y: -16'sd32768, range_upper: 16'hFFFF,
                     angle_start: -16'sd32768, angle_step: 16'sd32767};
            1: c.range_upper = 16'd0;
            2: begin
               c.angle_start = 16'sd32767;
               c.angle_step  = -16'sd32768;
            end
            default: ;
         endcase
         idling_on = (phase != 7);
         load_filter_cfg(c);
         scan_left = 0;
         for (int n = 0; n < 212; n++) begin
            if (scan_left == 0) begin
               first     = 1'b1;
               scan_left = $urandom_range(8, 64);
            end else begin
               first = ($urandom_range(0, 49) == 0);
               scan_left--;
            end
            pending_beams.push_back({random_range(), first});
         end
         drain_pipe();
      end

      repeat (10) @(posedge clock);
      if (expected_beams.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_beams.size()));
      end
      $display("Checked %0d of %0d samples over %0d register settings, %0d flagged removed.",
               checked_cnt, accepted_cnt, setting_cnt, removed_cnt);
      $display("Mismatches: %0d", mismatch_cnt);
      if (mismatch_cnt == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout waiting for results");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire

/* laser_scan_box_filter_core.f */
rtl/lsbf_pkg.sv
rtl/lsbf_req_if.sv
rtl/lsbf_rsp_if.sv
rtl/laser_scan_box_filter_core.sv
bench/tb.sv
